FILE: rtl/rms_pkg.sv
// shared types and constants for the running median stream unit
package rms_pkg;

  localparam int VALUE_W = 31;
  localparam int COUNT_W = 11;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;

  // per-cycle operation applied to a whole sorted chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE,
    OP_PUSH
  } chain_op_t;

  // control broadcast from the top level to every cell of one chain
  typedef struct packed {
    chain_op_t op;
    value_t    v;
  } chain_ctl_t;

endpackage

FILE: rtl/rms_cell.sv
// one cell of a sorted chain: holds a sample and trades it with its neighbors
module rms_cell (
  input  logic                clk,
  input  rms_pkg::chain_ctl_t ctl,
  input  logic                order_max,
  input  logic                head,
  input  logic                cell_valid,
  input  logic                keep_left,
  input  logic                keep_right,
  input  rms_pkg::value_t     left_val,
  input  rms_pkg::value_t     right_val,
  output logic                keep,
  output rms_pkg::value_t     val
);

  rms_pkg::value_t val_r;
  rms_pkg::value_t val_nxt;
  logic            better;

  // broadcast sample ranks ahead of this cell's sample
  always_comb begin
    better = order_max ? (ctl.v > val_r) : (ctl.v < val_r);
    keep   = cell_valid && !better;
  end

  // next value: hold, shift toward the tail, shift toward the head, or take the sample
  always_comb begin
    unique case (ctl.op)
      rms_pkg::OP_HOLD:    val_nxt = val_r;
      rms_pkg::OP_INSERT:  val_nxt = keep ? val_r : (keep_left ? ctl.v : left_val);
      rms_pkg::OP_REPLACE: val_nxt = keep_right ? right_val :
                                     ((head || keep) ? ctl.v : val_r);
      rms_pkg::OP_PUSH:    val_nxt = head ? ctl.v : left_val;
      default:             val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: rtl/rms_chain.sv
// sorted chain of cells, best-ranked sample at the head
module rms_chain #(
  parameter int DEPTH = 512,
  parameter int CNT_W = 11
) (
  input  logic                clk,
  input  rms_pkg::chain_ctl_t ctl,
  input  logic                order_max,
  input  logic [CNT_W-1:0]    size,
  output rms_pkg::value_t     top
);

  rms_pkg::value_t  vals [DEPTH];
  logic [DEPTH-1:0] keeps;

  // row of cells, each wired to its left and right neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            kl;
    logic            kr;
    logic            hd;
    rms_pkg::value_t lv;
    rms_pkg::value_t rv;

    if (i == 0) begin : g_first
      assign kl = 1'b1;
      assign lv = '0;
      assign hd = 1'b1;
    end else begin : g_mid_l
      assign kl = keeps[i-1];
      assign lv = vals[i-1];
      assign hd = 1'b0;
    end

    if (i == DEPTH - 1) begin : g_last
      assign kr = 1'b0;
      assign rv = '0;
    end else begin : g_mid_r
      assign kr = keeps[i+1];
      assign rv = vals[i+1];
    end

    rms_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .order_max  (order_max),
      .head       (hd),
      .cell_valid (CNT_W'(i) < size),
      .keep_left  (kl),
      .keep_right (kr),
      .left_val   (lv),
      .right_val  (rv),
      .keep       (keeps[i]),
      .val        (vals[i])
    );
  end

  assign top = vals[0];

endmodule

FILE: rtl/running_median_stream_unit.sv
// top level of the running median stream unit
//
//   channel | direction | ports                                  | handshake
//   in      | input     | in_value                               | in_valid / in_ready
//   out     | output    | out_median, out_count, out_full_res    | out_valid / out_ready
//
// while the output is not stalled, one word per cycle is taken; an accepted word updates the
// cell chains, the median is formed from the two chain heads in the next cycle and moves
// into the output register once that register is free.
// the cell chains need no clearing after reset: the sample count marks which cells hold data.
// a stalled output holds its word and the median stage; input stalls only when
// the median stage cannot move into the output register.
module running_median_stream_unit #(
  parameter int CAPACITY = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [30:0]            in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [30:0]            out_median,
  output logic [10:0]            out_count,
  output logic                   out_full_res
);

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LO_DEPTH = (CAPACITY + 1) / 2;
  localparam int UP_DEPTH = CAPACITY / 2;

  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [CNT_W:0]      cnt_inc;
  logic [CNT_W-1:0]    lo_size;
  logic [CNT_W-1:0]    up_size;
  logic                full;
  logic                in_acc;
  logic                out_free;
  rms_pkg::chain_ctl_t lo_ctl;
  rms_pkg::chain_ctl_t up_ctl;
  rms_pkg::value_t     lo_top;
  rms_pkg::value_t     up_top;

  logic                calc_v_r;
  logic                calc_v_nxt;
  logic                calc_full_r;
  logic                calc_full_nxt;
  logic [31:0]         sum;
  rms_pkg::value_t     median;

  logic                out_valid_r;
  logic                out_valid_nxt;
  rms_pkg::value_t     out_median_r;
  rms_pkg::count_t     out_count_r;
  logic                out_full_res_r;

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !calc_v_r || out_free;
  assign in_acc   = in_valid && in_ready;

  // sizes of the two halves follow from the sample count
  assign cnt_inc = {1'b0, cnt_r} + (CNT_W + 1)'(1);
  assign lo_size = cnt_inc[CNT_W:1];
  assign up_size = cnt_r >> 1;
  assign full    = (cnt_r == CNT_W'(CAPACITY));

  // choose chain operations for the incoming word
  always_comb begin
    lo_ctl.op = rms_pkg::OP_HOLD;
    lo_ctl.v  = in_value;
    up_ctl.op = rms_pkg::OP_HOLD;
    up_ctl.v  = in_value;
    if (in_acc && !full) begin
      if (cnt_r[0]) begin
        // lower half holds one extra sample
        if (in_value > lo_top) begin
          up_ctl.op = rms_pkg::OP_INSERT;
        end else begin
          up_ctl.op = rms_pkg::OP_PUSH;
          up_ctl.v  = lo_top;
          lo_ctl.op = rms_pkg::OP_REPLACE;
        end
      end else begin
        // halves balanced
        if (cnt_r == '0 || in_value <= up_top) begin
          lo_ctl.op = rms_pkg::OP_INSERT;
        end else begin
          lo_ctl.op = rms_pkg::OP_PUSH;
          lo_ctl.v  = up_top;
          up_ctl.op = rms_pkg::OP_REPLACE;
        end
      end
    end
  end

  // lower half, largest sample at the head
  rms_chain #(
    .DEPTH (LO_DEPTH),
    .CNT_W (CNT_W)
  ) u_lower (
    .clk       (clk),
    .ctl       (lo_ctl),
    .order_max (1'b1),
    .size      (lo_size),
    .top       (lo_top)
  );

  // upper half, smallest sample at the head
  rms_chain #(
    .DEPTH (UP_DEPTH),
    .CNT_W (CNT_W)
  ) u_upper (
    .clk       (clk),
    .ctl       (up_ctl),
    .order_max (1'b0),
    .size      (up_size),
    .top       (up_top)
  );

  // sample count and median stage control
  always_comb begin
    cnt_nxt       = (in_acc && !full) ? cnt_inc[CNT_W-1:0] : cnt_r;
    calc_v_nxt    = in_acc || (calc_v_r && !out_free);
    calc_full_nxt = in_acc ? full : calc_full_r;
    out_valid_nxt = (calc_v_r && out_free) || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      calc_v_r    <= 1'b0;
      calc_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      calc_v_r    <= calc_v_nxt;
      calc_full_r <= calc_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // median from the chain heads; even count averages with a 32-bit sum
  assign sum    = {1'b0, lo_top} + {1'b0, up_top};
  assign median = cnt_r[0] ? lo_top : sum[31:1];

  // output register
  always_ff @(posedge clk) begin
    if (calc_v_r && out_free) begin
      out_median_r   <= median;
      out_count_r    <= rms_pkg::COUNT_W'(cnt_r);
      out_full_res_r <= calc_full_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_median   = out_median_r;
  assign out_count    = out_count_r;
  assign out_full_res = out_full_res_r;

endmodule

FILE: rtl/rms_checker.sv
// port-level checks for the running median stream unit, bound to the top level
module rms_checker #(
  parameter int CAPACITY = 1024
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [30:0] in_value,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] out_median,
  input logic [10:0] out_count,
  input logic        out_full_res
);

  // no result word right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median) &&
                                $stable(out_count) && $stable(out_full_res))
    else $error("stalled result word changed");

  // every accepted word is followed by a valid result word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result word after accepted input");

  // a dropped word reports a full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_count == 11'(CAPACITY))
    else $error("full flag without full count");

  // an accepted input word carries no unknown bits
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !$isunknown(in_value))
    else $error("unknown input value accepted");

endmodule

bind running_median_stream_unit rms_checker #(
  .CAPACITY (CAPACITY)
) u_rms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_value     (in_value),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_median   (out_median),
  .out_count    (out_count),
  .out_full_res (out_full_res)
);

FILE: bench/tb_running_median_stream_unit.sv
// self-checking testbench for the running median stream unit
module tb_running_median_stream_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 1024;
  localparam int RANDOM_WORDS = 1830;
  localparam int CALM_WORDS   = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam rms_pkg::value_t TOP_VALUE = 31'h7FFF_FFFF;

  // one result word as the block reports it
  typedef struct packed {
    rms_pkg::value_t median;
    rms_pkg::count_t count;
    logic            full;
  } median_word_t;

  // one row of the directed table; typed rows carry their own expected word
  typedef struct packed {
    rms_pkg::value_t value;
    logic            typed;
    median_word_t    word;
  } plan_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  rms_pkg::value_t in_value = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  rms_pkg::value_t out_median;
  rms_pkg::count_t out_count;
  logic            out_full_res;

  // sorted halves of the samples seen so far, ascending
  rms_pkg::value_t lower_vals[$];
  rms_pkg::value_t upper_vals[$];
  int              samples_taken = 0;
  rms_pkg::value_t last_median = '0;

  median_word_t medians_due[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  // directed words: extremes first, then mixed values checked by the predictor
  plan_row_t plan [0:17] = '{
    '{TOP_VALUE,     1'b1, '{TOP_VALUE,     11'd1, 1'b0}},
    '{TOP_VALUE,     1'b1, '{TOP_VALUE,     11'd2, 1'b0}},
    '{31'h0,         1'b1, '{TOP_VALUE,     11'd3, 1'b0}},
    '{31'h0,         1'b1, '{31'h3FFF_FFFF, 11'd4, 1'b0}},
    '{31'h0,         1'b1, '{31'h0,         11'd5, 1'b0}},
    '{31'h1,         1'b1, '{31'h0,         11'd6, 1'b0}},
    '{31'h7FFF_FFFE, 1'b0, '0},
    '{31'h4000_0000, 1'b0, '0},
    '{31'h3FFF_FFFF, 1'b0, '0},
    '{31'h5555_5555, 1'b0, '0},
    '{31'h2AAA_AAAA, 1'b0, '0},
    '{31'h1,         1'b0, '0},
    '{31'h7FFF_FFFE, 1'b0, '0},
    '{31'h1234_5678, 1'b0, '0},
    '{31'h4000_0000, 1'b0, '0},
    '{31'h2,         1'b0, '0},
    '{TOP_VALUE,     1'b0, '0},
    '{31'h0000_FFFF, 1'b0, '0}
  };

  running_median_stream_unit #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_median   (out_median),
    .out_count    (out_count),
    .out_full_res (out_full_res)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // keep a queue ascending while adding one value
  function automatic void place_sorted(ref rms_pkg::value_t q[$], input rms_pkg::value_t v);
    int pos;
    pos = q.size();
    while (pos > 0 && q[pos-1] > v) pos--;
    q.insert(pos, v);
  endfunction

  // add one sample to the halves and form the word the block should report
  function automatic median_word_t absorb_sample(rms_pkg::value_t v);
    median_word_t    w;
    rms_pkg::value_t moved;
    logic [31:0]     pair_sum;
    w.full = 1'b0;
    if (samples_taken >= CAPACITY) begin
      w.full = 1'b1;
    end else if (lower_vals.size() > upper_vals.size()) begin
      if (v > lower_vals[$]) begin
        place_sorted(upper_vals, v);
      end else begin
        // lower top moves across to become the upper front
        moved = lower_vals.pop_back();
        upper_vals.push_front(moved);
        place_sorted(lower_vals, v);
      end
      samples_taken++;
    end else begin
      if (upper_vals.size() == 0 || v <= upper_vals[0]) begin
        place_sorted(lower_vals, v);
      end else begin
        // upper front moves across to the top of the lower half
        moved = upper_vals.pop_front();
        lower_vals.push_back(moved);
        place_sorted(upper_vals, v);
      end
      samples_taken++;
    end
    if (lower_vals.size() == 0) begin
      w.median = '0;
    end else if (lower_vals.size() > upper_vals.size()) begin
      w.median = lower_vals[$];
    end else begin
      pair_sum = {1'b0, lower_vals[$]} + {1'b0, upper_vals[0]};
      w.median = pair_sum[31:1];
    end
    w.count = samples_taken[10:0];
    last_median = w.median;
    return w;
  endfunction

  // random sample: full range, clusters of duplicates, extremes, near the median
  function automatic rms_pkg::value_t pick_value();
    rms_pkg::value_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = rms_pkg::value_t'($urandom());
      4, 5:       v = rms_pkg::value_t'($urandom_range(0, 15));
      6:          v = TOP_VALUE - rms_pkg::value_t'($urandom_range(0, 7));
      7:          v = rms_pkg::value_t'($urandom_range(0, 3));
      8:          v = last_median + rms_pkg::value_t'($urandom_range(0, 4)) -
                      rms_pkg::value_t'(2);
      default:    v = 31'h4000_0000 + rms_pkg::value_t'($urandom_range(0, 3)) -
                      rms_pkg::value_t'(1);
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // offer one word, wait for it to be taken, then maybe leave a gap
  task automatic send_word(rms_pkg::value_t v, logic typed, median_word_t typed_word);
    median_word_t w;
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    w = absorb_sample(v);
    if (typed) w = typed_word;
    medians_due.push_back(w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold the input off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (medians_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, none in the calm tail
  initial begin
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold == 0 && !calm && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 5);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result word with the oldest expected one
  always @(posedge clk) begin
    median_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (medians_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word median %0h count %0d full %0b",
                                out_median, out_count, out_full_res));
      end else begin
        want = medians_due.pop_front();
        if (out_median !== want.median)
          flag_mismatch($sformatf("median %0h, want %0h", out_median, want.median));
        if (out_count !== want.count)
          flag_mismatch($sformatf("count %0d, want %0d", out_count, want.count));
        if (out_full_res !== want.full)
          flag_mismatch($sformatf("full_res %0b, want %0b", out_full_res, want.full));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_running_median_stream_unit failed");
      $finish;
    end
  end

  // stimulus: directed table, a full drain, then random words until well past capacity, drained halfway
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[i]) send_word(plan[i].value, plan[i].typed, plan[i].word);
    drain_results();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain_results();
      if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      send_word(pick_value(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_running_median_stream_unit passed");
    end else begin
      $display("tb_running_median_stream_unit failed");
    end
    $finish;
  end

endmodule
